@@ sv/sliding_window_mode_filter_top_defines.svh @@
// Assertion shorthands shared by the RTL. Each expects clk and rst in scope.
`ifndef SLIDING_WINDOW_MODE_FILTER_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MODE_FILTER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWMF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/swmf_pkg.sv @@
package swmf_pkg;

  localparam int LABEL_W = 3;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic               op;
    logic               lane_side;
    logic [LABEL_W-1:0] label_class;
  } req_t;

  typedef struct packed {
    logic [LABEL_W-1:0] mode_class;
    logic               side_echo;
  } rsp_t;

endpackage

@@ sv/swmf_cell.sv @@
module swmf_cell (
  input  logic                       clk,
  input  logic                       shift,
  input  logic [swmf_pkg::LABEL_W-1:0] din,
  output logic [swmf_pkg::LABEL_W-1:0] dout
);
  import swmf_pkg::*;

  // hold the label until this side's window advances
  always_ff @(posedge clk) begin
    if (shift) begin
      dout <= din;
    end
  end

endmodule

@@ sv/swmf_argmax.sv @@
module swmf_argmax #(
  parameter int NCLS = 8,
  parameter int CW   = 5
) (
  input  logic [CW-1:0]                cnt [NCLS],
  output logic [swmf_pkg::LABEL_W-1:0] best
);
  import swmf_pkg::*;

  logic [CW-1:0] best_cnt;

  // strict greater-than keeps the lowest class on ties
  always_comb begin
    best_cnt = '0;
    best     = '0;
    for (int c = 0; c < NCLS; c++) begin
      if (cnt[c] > best_cnt) begin
        best_cnt = cnt[c];
        best     = LABEL_W'(c);
      end
    end
  end

endmodule

@@ sv/sliding_window_mode_filter_top.sv @@
// An accepted push request becomes the argmax stage token; its result then moves
//   into the output register that drives rsp, which holds it while stalled.
// Throughput: one request per cycle while no result is stalled on rsp, set by
//   the per-class running counters updated next to the label shift chains.
// Reset (rst, synchronous): empties both windows, zeroes all class counts and
//   drops any result in flight; the label cells themselves are not reset.
`include "sliding_window_mode_filter_top_defines.svh"

module sliding_window_mode_filter_top #(
  parameter int WINDOW  = 30,
  parameter int CLASSES = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  swmf_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output swmf_pkg::rsp_t rsp
);
  import swmf_pkg::*;

  // Labels are 3 bits wide, so at most eight classes can ever be counted.
  localparam int NCLS = (CLASSES < 8) ? CLASSES : 8;
  localparam int CW   = $clog2(WINDOW + 1);

  // Per-side label chains: cell 0 holds the newest label, the last cell the
  // oldest once the window is full.
  logic [LABEL_W-1:0] cell_q [2][WINDOW];
  logic [1:0]         shift_en;

  // Running state: fill level and class counts per side.
  logic [CW-1:0] fill_level       [2];
  logic [CW-1:0] fill_level_next  [2];
  logic [CW-1:0] class_counts     [2][NCLS];
  logic [CW-1:0] class_counts_next[2][NCLS];
  logic [1:0]    full;

  // Argmax stage token and output register.
  logic          a_valid;
  logic          a_side;
  logic          adv;
  logic [CW-1:0] sel_counts [NCLS];
  logic [LABEL_W-1:0] mode_best;

  logic               req_acc;
  logic               push;
  logic               clr;
  logic [LABEL_W-1:0] lbl;
  logic [LABEL_W-1:0] old_lbl;

  // Accept side: the output register frees the argmax stage, so a request is
  // held off only when a token waits behind a stalled result.
  assign adv       = !rsp_valid || !rsp_stall;
  assign req_stall = a_valid && !adv;
  assign req_acc   = req_valid && !req_stall;
  assign push      = req_acc && (req.op == OP_PUSH);
  assign clr       = req_acc && (req.op == OP_CLEAR);

  // Saturate out-of-range labels to the top class before storing or counting.
  assign lbl = ({1'b0, req.label_class} >= 4'(NCLS)) ? LABEL_W'(NCLS - 1)
                                                     : req.label_class;

  assign full[0] = (fill_level[0] == CW'(WINDOW));
  assign full[1] = (fill_level[1] == CW'(WINDOW));

  // Oldest label of the addressed side, valid only when that side is full.
  assign old_lbl = cell_q[req.lane_side][WINDOW-1];

  assign shift_en[0] = push && (req.lane_side == 1'b0);
  assign shift_en[1] = push && (req.lane_side == 1'b1);

  // Build the two shift chains out of identical cells.
  for (genvar s = 0; s < 2; s++) begin : g_side
    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      if (i == 0) begin : g_head
        swmf_cell u_cell (
          .clk  (clk),
          .shift(shift_en[s]),
          .din  (lbl),
          .dout (cell_q[s][i])
        );
      end else begin : g_body
        swmf_cell u_cell (
          .clk  (clk),
          .shift(shift_en[s]),
          .din  (cell_q[s][i-1]),
          .dout (cell_q[s][i])
        );
      end
    end
  end

  // Count update: clear zeroes both sides; else increment the new label and
  // decrement the evicted one when full. Both on one class leaves it unchanged.
  always_comb begin
    for (int s = 0; s < 2; s++) begin
      fill_level_next[s] = fill_level[s];
      if (clr) begin
        fill_level_next[s] = '0;
      end else if (shift_en[s] && !full[s]) begin
        fill_level_next[s] = fill_level[s] + CW'(1);
      end
      for (int c = 0; c < NCLS; c++) begin
        if (clr) begin
          class_counts_next[s][c] = '0;
        end else begin
          class_counts_next[s][c] = class_counts[s][c]
            + CW'(shift_en[s] && (lbl == LABEL_W'(c)))
            - CW'(shift_en[s] && full[s] && (old_lbl == LABEL_W'(c)));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 2; s++) begin
        fill_level[s] <= '0;
        for (int c = 0; c < NCLS; c++) begin
          class_counts[s][c] <= '0;
        end
      end
    end else begin
      fill_level   <= fill_level_next;
      class_counts <= class_counts_next;
    end
  end

  // Argmax stage reads the counts left by the token's own push: any later
  // push lands at the same edge that moves the token into the output register.
  always_comb begin
    for (int c = 0; c < NCLS; c++) begin
      sel_counts[c] = class_counts[a_side][c];
    end
  end

  swmf_argmax #(
    .NCLS(NCLS),
    .CW  (CW)
  ) u_argmax (
    .cnt (sel_counts),
    .best(mode_best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (push) begin
      a_valid <= 1'b1;
    end else if (adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      a_side <= req.lane_side;
    end
  end

  // Output register: load on advance, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && a_valid) begin
      rsp.mode_class <= mode_best;
      rsp.side_echo  <= a_side;
    end
  end

  `SWMF_ASSERT_NEXT(a_clear_empties, clr, (fill_level[0] == '0) && (fill_level[1] == '0), "clear did not empty both windows")
  `SWMF_ASSERT_NEXT(a_push_token, push, a_valid, "push did not create a result token")
  `SWMF_ASSERT_SAME(a_hold_off, a_valid && rsp_valid && rsp_stall, req_stall, "request taken while token is blocked")
  `SWMF_ASSERT_NEXT(a_fill_grow, push && !full[req.lane_side], fill_level[$past(req.lane_side)] == $past(fill_level[req.lane_side]) + CW'(1), "fill level did not advance on push")

endmodule
